[rtl/kpl_pkg.sv]
// Package for the keypad PIN lock controller: request types, mode and event codes,
// key codes and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kpl_pkg;

    // Longest entry or stored PIN, in symbols.
    localparam int MAX_SYMBOLS = 16;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int IDX_W       = $clog2(MAX_SYMBOLS);
    localparam int SYM_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [4:0]  MIN_LEN_RESET    = 5'd4;
    localparam logic [15:0] HOLD_MS_RESET    = 16'd4000;

    localparam logic [7:0] KEY_0     = 8'h30;
    localparam logic [7:0] KEY_9     = 8'h39;
    localparam logic [7:0] KEY_HASH  = 8'h23;
    localparam logic [7:0] KEY_ENTER = 8'h41;
    localparam logic [7:0] KEY_BACK  = 8'h42;
    localparam logic [7:0] KEY_CLEAR = 8'h43;
    localparam logic [7:0] KEY_DEL   = 8'h44;
    localparam logic [7:0] KEY_MASK  = 8'h2A;
    localparam logic [7:0] KEY_NONE  = 8'h20;

    localparam logic [SYM_W-1:0] SYM_HASH = 4'd10;

    typedef enum logic [2:0] {
        MODE_INIT      = 3'd0,
        MODE_TRY       = 3'd1,
        MODE_SET_FIRST = 3'd2,
        MODE_CONFIRM   = 3'd3,
        MODE_NEW       = 3'd4,
        MODE_OPEN      = 3'd5,
        MODE_RESET     = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        EV_NONE    = 4'd0,
        EV_SHORT   = 4'd1,
        EV_LONG    = 4'd2,
        EV_SAVED   = 4'd3,
        EV_CORRECT = 4'd4,
        EV_WRONG   = 4'd5,
        EV_UNUSED  = 4'd6,
        EV_CLOSED  = 4'd7,
        EV_FACTORY = 4'd8
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PIN_LENGTH = 2'd0,
        CFG_RESET_HOLD_MS  = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]  key_char;
        logic [15:0] press_ms;
    } key_req_t;

    typedef struct packed {
        logic [2:0]  lock_mode;
        logic [4:0]  entry_length;
        logic [3:0]  last_symbol;
        logic        display_masked;
        logic        lamp_on;
        logic [3:0]  event_code;
    } lock_rsp_t;

endpackage

`default_nettype wire

[rtl/keypad_pin_lock_controller.sv]
// Keypad PIN lock controller top level: input register, mode decision and entry
// editing, result register. Depends on kpl_pkg.
//
//   Channel   Signals                                   Carries
//   in        in_valid, in_ready, in_data               key request (key_char, press_ms)
//   out       out_valid, out_ready, out_data            result (mode, entry, mask, lamp, event)
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write, always ready
//
// One key request is taken every cycle unless the result side stalls; a request is
// held in the input register first, then its result goes into the result register.
// The longest path is the 16-symbol PIN compare feeding the mode decision.
// Reset clears mode, counts, flags and both pipeline valids; the symbol arrays are
// left as they are, since only entries below a count are ever read.
// A stalled result holds the input register, and the input side stalls only when both
// registers are full.
`timescale 1ns / 1ps
`default_nettype none

module keypad_pin_lock_controller
    import kpl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire key_req_t              in_data,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      lock_rsp_t             out_data,
    input  wire logic                  cfg_valid,
    output      logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic              in_valid_reg;
    key_req_t          in_reg;
    logic              out_valid_reg;
    lock_rsp_t         out_reg;
    logic              advance;

    logic [4:0]        min_len_reg;
    logic [15:0]       hold_ms_reg;

    mode_t             mode_reg, mode_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              mask_reg, mask_next;
    logic              lamp_reg, lamp_next;
    logic [CNT_W-1:0]  scnt_reg, scnt_next;
    logic              svalid_reg, svalid_next;
    logic [SYM_W-1:0]  entry_reg [MAX_SYMBOLS];
    logic [SYM_W-1:0]  entry_next [MAX_SYMBOLS];
    logic [SYM_W-1:0]  stored_reg [MAX_SYMBOLS];

    event_t            ev;
    logic              wr_sym;
    logic              save_pin;
    logic              is_sym;
    logic [SYM_W-1:0]  sym_val;
    logic              long_clear;
    logic              pin_match;
    logic [MAX_SYMBOLS-1:0] sym_eq;
    logic [SYM_W-1:0]  last_sym;
    lock_rsp_t         rsp;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            hold_ms_reg <= HOLD_MS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MIN_PIN_LENGTH: min_len_reg <= cfg_data[4:0];
                CFG_RESET_HOLD_MS:  hold_ms_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Key classification.
    assign is_sym  = (in_reg.key_char inside {[KEY_0:KEY_9], KEY_HASH});
    assign sym_val = (in_reg.key_char == KEY_HASH) ? SYM_HASH
                                                   : SYM_W'(in_reg.key_char - KEY_0);
    assign long_clear = (mode_reg != MODE_INIT) && (mode_reg != MODE_SET_FIRST)
                        && (in_reg.key_char == KEY_CLEAR)
                        && (in_reg.press_ms > hold_ms_reg);

    // Only symbols below the entry count take part in the match.
    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            sym_eq[i] = (CNT_W'(i) >= cnt_reg) || (stored_reg[i] == entry_reg[i]);
        end
    end
    assign pin_match = svalid_reg && (scnt_reg == cnt_reg) && (&sym_eq);

    // Next mode and event, plus the editing actions that go with them.
    always_comb
    begin
        mode_next   = mode_reg;
        ev          = EV_NONE;
        cnt_next    = cnt_reg;
        mask_next   = mask_reg;
        lamp_next   = lamp_reg;
        scnt_next   = scnt_reg;
        svalid_next = svalid_reg;
        wr_sym      = 1'b0;
        save_pin    = 1'b0;
        if (long_clear)
        begin
            mode_next = MODE_RESET;
        end
        else if (mode_reg == MODE_INIT)
        begin
            mode_next = svalid_reg ? MODE_TRY : MODE_SET_FIRST;
        end
        else if (mode_reg == MODE_OPEN)
        begin
            if (in_reg.key_char == KEY_BACK)
            begin
                lamp_next = 1'b0;
                mode_next = MODE_TRY;
                ev        = EV_CLOSED;
            end
            else if (in_reg.key_char != KEY_NONE)
            begin
                ev = EV_UNUSED;
            end
        end
        else if (in_reg.key_char == KEY_NONE)
        begin
            ev = EV_NONE;
        end
        else if (in_reg.key_char == KEY_DEL)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
        else if (in_reg.key_char == KEY_CLEAR)
        begin
            cnt_next = '0;
        end
        else if ((in_reg.key_char == KEY_ENTER) && (cnt_reg < CNT_W'(min_len_reg))
                 || ((in_reg.key_char == KEY_ENTER) && (min_len_reg > 5'(MAX_SYMBOLS))))
        begin
            cnt_next = '0;
            ev       = EV_SHORT;
        end
        else if (is_sym && (cnt_reg >= CNT_W'(MAX_SYMBOLS)))
        begin
            cnt_next = '0;
            ev       = EV_LONG;
        end
        else if (in_reg.key_char == KEY_MASK)
        begin
            mask_next = !mask_reg;
        end
        else if (is_sym)
        begin
            wr_sym   = 1'b1;
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if ((in_reg.key_char == KEY_BACK) && (mode_reg != MODE_SET_FIRST))
        begin
            mode_next = (mode_reg == MODE_TRY) ? MODE_CONFIRM : MODE_TRY;
        end
        else if (in_reg.key_char == KEY_ENTER)
        begin
            if ((mode_reg == MODE_SET_FIRST) || (mode_reg == MODE_NEW))
            begin
                save_pin    = 1'b1;
                scnt_next   = cnt_reg;
                svalid_next = 1'b1;
                mode_next   = MODE_TRY;
                ev          = EV_SAVED;
            end
            else if (pin_match)
            begin
                ev = EV_CORRECT;
                case (mode_reg)
                    MODE_TRY:     mode_next = MODE_OPEN;
                    MODE_CONFIRM: mode_next = MODE_NEW;
                    default:
                    begin
                        svalid_next = 1'b0;
                        scnt_next   = '0;
                        mask_next   = 1'b1;
                        lamp_next   = 1'b0;
                        mode_next   = MODE_INIT;
                        ev          = EV_FACTORY;
                    end
                endcase
            end
            else
            begin
                cnt_next = '0;
                ev       = EV_WRONG;
            end
        end
        else
        begin
            ev = EV_UNUSED;
        end
        if (mode_next != mode_reg)
        begin
            cnt_next = '0;
            if (mode_next == MODE_OPEN)
            begin
                lamp_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_SYMBOLS; i++)
        begin
            entry_next[i] = entry_reg[i];
        end
        if (wr_sym)
        begin
            entry_next[cnt_reg[IDX_W-1:0]] = sym_val;
        end
    end

    // Result formed from the updated entry.
    always_comb
    begin
        last_sym = (cnt_next != '0) ? entry_next[IDX_W'(cnt_next - CNT_W'(1))] : '0;
        rsp.lock_mode      = mode_next;
        rsp.entry_length   = 5'(cnt_next);
        rsp.last_symbol    = last_sym;
        rsp.display_masked = mask_next;
        rsp.lamp_on        = lamp_next;
        rsp.event_code     = ev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_INIT;
            cnt_reg       <= '0;
            mask_reg      <= 1'b1;
            lamp_reg      <= 1'b0;
            scnt_reg      <= '0;
            svalid_reg    <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg   <= mode_next;
                cnt_reg    <= cnt_next;
                mask_reg   <= mask_next;
                lamp_reg   <= lamp_next;
                scnt_reg   <= scnt_next;
                svalid_reg <= svalid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= rsp;
            for (int i = 0; i < MAX_SYMBOLS; i++)
            begin
                entry_reg[i] <= entry_next[i];
                if (save_pin)
                begin
                    stored_reg[i] <= entry_reg[i];
                end
            end
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("entry count beyond capacity");

    a_wiped_pin: assert property (@(posedge clk) disable iff (!rst_n)
        !svalid_reg |-> (scnt_reg == '0))
        else $error("stored count set without a saved PIN");

    a_open_needs_pin: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_OPEN) |-> svalid_reg)
        else $error("lock open with no saved PIN");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

endmodule

`default_nettype wire

[tb/pin_lock_scoreboard.sv]
// Scoreboard for the keypad PIN lock testbench: predicts the result of every key
// request and checks the results that come back. Depends on kpl_pkg.
`timescale 1ns / 1ps

package pin_lock_tb_pkg;

    import kpl_pkg::*;

    class pin_lock_scoreboard;

        // Configuration and lock state, as the block should hold them.
        int          min_len;
        int          hold_ms;
        mode_t       mode;
        logic [3:0]  entry [MAX_SYMBOLS];
        int          entry_len;
        bit          masked;
        logic [3:0]  stored [MAX_SYMBOLS];
        int          stored_len;
        bit          pin_saved;
        bit          lamp;

        lock_rsp_t   results_due [$];
        int          errors;

        function new();
            int i;
            min_len    = MIN_LEN_RESET;
            hold_ms    = HOLD_MS_RESET;
            mode       = MODE_INIT;
            entry_len  = 0;
            masked     = 1'b1;
            stored_len = 0;
            pin_saved  = 1'b0;
            lamp       = 1'b0;
            errors     = 0;
            for (i = 0; i < MAX_SYMBOLS; i++)
            begin
                entry[i]  = '0;
                stored[i] = '0;
            end
        endfunction

        function void apply_config(cfg_index_t idx, logic [15:0] data);
            if (idx == CFG_MIN_PIN_LENGTH)
                min_len = data[4:0];
            else if (idx == CFG_RESET_HOLD_MS)
                hold_ms = data;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Runs one accepted key request through the lock and queues the result.
        function void note_key(key_req_t req);
            mode_t      cur;
            mode_t      nxt;
            event_t     ev;
            logic [7:0] k;
            int         sym;
            int         i;
            bit         used;
            bit         same;
            lock_rsp_t  want;
            k   = req.key_char;
            cur = mode;
            nxt = cur;
            ev  = EV_NONE;
            sym = -1;
            if (k >= KEY_0 && k <= KEY_9)
                sym = k - KEY_0;
            else if (k == KEY_HASH)
                sym = SYM_HASH;

            if (cur != MODE_INIT && cur != MODE_SET_FIRST && k == KEY_CLEAR
                && req.press_ms > hold_ms)
            begin
                nxt = MODE_RESET;
            end
            else if (cur == MODE_INIT)
            begin
                nxt = pin_saved ? MODE_TRY : MODE_SET_FIRST;
            end
            else if (cur == MODE_OPEN)
            begin
                if (k == KEY_BACK)
                begin
                    lamp = 1'b0;
                    nxt  = MODE_TRY;
                    ev   = EV_CLOSED;
                end
                else if (k != KEY_NONE)
                    ev = EV_UNUSED;
            end
            else
            begin
                // Editing keys are shared by every mode that takes an entry.
                used = 1'b1;
                if (k == KEY_DEL)
                begin
                    if (entry_len > 0)
                        entry_len--;
                end
                else if (k == KEY_CLEAR)
                    entry_len = 0;
                else if (k == KEY_ENTER && entry_len < min_len)
                begin
                    entry_len = 0;
                    ev        = EV_SHORT;
                end
                else if (sym >= 0 && entry_len >= MAX_SYMBOLS)
                begin
                    entry_len = 0;
                    ev        = EV_LONG;
                end
                else if (k == KEY_MASK)
                    masked = ~masked;
                else if (sym >= 0)
                begin
                    entry[entry_len] = 4'(sym);
                    entry_len++;
                end
                else if (k != KEY_NONE)
                    used = 1'b0;

                if (!used)
                begin
                    if (k == KEY_BACK && cur != MODE_SET_FIRST)
                        nxt = (cur == MODE_TRY) ? MODE_CONFIRM : MODE_TRY;
                    else if (k == KEY_ENTER)
                    begin
                        if (cur == MODE_SET_FIRST || cur == MODE_NEW)
                        begin
                            stored     = entry;
                            stored_len = entry_len;
                            pin_saved  = 1'b1;
                            nxt        = MODE_TRY;
                            ev         = EV_SAVED;
                        end
                        else
                        begin
                            same = pin_saved && (stored_len == entry_len);
                            for (i = 0; same && i < entry_len; i++)
                                if (stored[i] != entry[i])
                                    same = 1'b0;
                            if (!same)
                            begin
                                entry_len = 0;
                                ev        = EV_WRONG;
                            end
                            else if (cur == MODE_TRY)
                            begin
                                nxt = MODE_OPEN;
                                ev  = EV_CORRECT;
                            end
                            else if (cur == MODE_CONFIRM)
                            begin
                                nxt = MODE_NEW;
                                ev  = EV_CORRECT;
                            end
                            else
                            begin
                                // A verified PIN in reset mode wipes the lock.
                                pin_saved  = 1'b0;
                                stored_len = 0;
                                masked     = 1'b1;
                                lamp       = 1'b0;
                                nxt        = MODE_INIT;
                                ev         = EV_FACTORY;
                            end
                        end
                    end
                    else
                        ev = EV_UNUSED;
                end
            end

            if (nxt != cur)
            begin
                entry_len = 0;
                if (nxt == MODE_OPEN)
                    lamp = 1'b1;
            end
            mode = nxt;

            want.lock_mode      = mode;
            want.entry_length   = 5'(entry_len);
            want.last_symbol    = (entry_len > 0) ? entry[entry_len - 1] : '0;
            want.display_masked = masked;
            want.lamp_on        = lamp;
            want.event_code     = ev;
            results_due.push_back(want);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(lock_rsp_t got);
            lock_rsp_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: result %h with no request waiting", $time, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("lock_mode", 16'(want.lock_mode), 16'(got.lock_mode));
            compare_field("entry_length", 16'(want.entry_length), 16'(got.entry_length));
            compare_field("last_symbol", 16'(want.last_symbol), 16'(got.last_symbol));
            compare_field("display_masked", 16'(want.display_masked),
                          16'(got.display_masked));
            compare_field("lamp_on", 16'(want.lamp_on), 16'(got.lamp_on));
            compare_field("event_code", 16'(want.event_code), 16'(got.event_code));
        endfunction

    endclass

endpackage

[tb/tb_keypad_pin_lock_controller.sv]
// Testbench top for the keypad PIN lock controller: drives key requests and register
// writes with random gaps and stalls, and checks every result through the scoreboard.
// Depends on kpl_pkg, pin_lock_tb_pkg and the RTL.
`timescale 1ns / 1ps

module tb_keypad_pin_lock_controller;

    import kpl_pkg::*;
    import pin_lock_tb_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int KEYS_PER_PHASE = 245;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    key_req_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    lock_rsp_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pin_lock_scoreboard sb;
    int                 burst_left;
    int                 keys_sent;

    keypad_pin_lock_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_key(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // The result side alternates between free flow, random stalls, a sparse
    // pattern and long holds.
    initial
    begin : result_sink
        int span;
        int style;
        int k;
        out_ready = 1'b0;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 64);
            for (k = 0; k < span; k++)
            begin
                @(negedge clk);
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= (k % 5 == 4);
                    default: out_ready <= (k >= span / 2);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_keypad_pin_lock_controller: errors");
        $finish;
    end

    function automatic logic [15:0] any_press();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] clear_press(bit long_hold);
        if (long_hold && sb.hold_ms < 65535)
            return 16'($urandom_range(sb.hold_ms + 1, 65535));
        return 16'($urandom_range(0, sb.hold_ms));
    endfunction

    function automatic logic [7:0] symbol_key(int s);
        return (s == SYM_HASH) ? KEY_HASH : KEY_0 + 8'(s);
    endfunction

    function automatic int pin_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 8);
        if (r < 95)
            return $urandom_range(9, MAX_SYMBOLS);
        return MAX_SYMBOLS + 1;
    endfunction

    // Presents one request and returns at the falling edge after it was taken.
    // The sender works in bursts; a gap may open before a new burst.
    task automatic send_key(input logic [7:0] k, input logic [15:0] p);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{key_char: k, press_ms: p};
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        burst_left--;
        keys_sent++;
    endtask

    task automatic key_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_key(s[i], any_press());
    endtask

    // Types a PIN and submits it, now and then with a corrected typo or a mask toggle.
    task automatic enter_pin(input bit from_store, input int len, input bit spoil);
        int i;
        int s;
        int bad_at;
        bad_at = spoil ? $urandom_range(0, (len > 0) ? len - 1 : 0) : -1;
        for (i = 0; i < len; i++)
        begin
            if (from_store && i < sb.stored_len)
                s = sb.stored[i];
            else
                s = $urandom_range(0, 10);
            if (i == bad_at)
                s = (s + $urandom_range(1, 10)) % 11;
            if ($urandom_range(0, 15) == 0)
            begin
                send_key(symbol_key($urandom_range(0, 9)), any_press());
                send_key(KEY_DEL, any_press());
            end
            if ($urandom_range(0, 29) == 0)
                send_key(KEY_MASK, any_press());
            send_key(symbol_key(s), any_press());
        end
        send_key(KEY_ENTER, any_press());
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_config(idx, data);
        @(negedge clk);
    endtask

    // Stops requests and waits until every result is back and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int         phase;
        int         goal;
        int         pick;
        int         len;
        logic [4:0] min_len;
        logic [15:0] hold;
        in_valid   = 1'b0;
        in_data    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        rst_n      = 1'b0;
        burst_left = 0;
        keys_sent  = 0;
        sb         = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed walk through the modes with the reset settings.
        send_key(8'hFF, 16'h0000);          // any key leaves the initial mode
        send_key(KEY_ENTER, 16'hFFFF);      // empty entry is too short
        send_key(KEY_DEL, 16'h0000);        // delete on an empty entry
        key_string("9#00");
        send_key(KEY_MASK, 16'hFFFF);
        send_key(KEY_ENTER, 16'h0000);      // first PIN saved
        send_key(KEY_BACK, 16'hFFFF);       // try to confirm current
        send_key(KEY_BACK, 16'h0000);       // and back to try
        key_string("9#05");
        send_key(KEY_ENTER, 16'hFFFF);      // wrong PIN
        key_string("9#00");
        send_key(KEY_ENTER, 16'h0000);      // lock opens
        send_key(8'h00, 16'hFFFF);          // unused key while open
        send_key(KEY_NONE, 16'h0000);
        send_key(KEY_CLEAR, 16'hFFFF);      // long clear from open enters reset
        send_key(KEY_CLEAR, 16'hFFFF);      // long clear in reset does nothing
        key_string("9#00");
        send_key(KEY_ENTER, 16'h8000);      // factory reset

        for (phase = 0; phase < 7; phase++)
        begin
            if (phase > 0)
            begin
                settle();
                case (phase)
                    1:
                    begin
                        min_len = 5'd1;
                        hold    = 16'd0;
                    end
                    2:
                    begin
                        min_len = 5'd16;
                        hold    = 16'hFFFF;
                    end
                    3:
                    begin
                        min_len = 5'd0;
                        hold    = 16'd1000;
                    end
                    4:
                    begin
                        min_len = 5'd31;
                        hold    = 16'd300;
                    end
                    5:
                    begin
                        min_len = 5'd6;
                        hold    = 16'd4000;
                    end
                    default:
                    begin
                        min_len = 5'($urandom_range(2, 12));
                        hold    = any_press();
                    end
                endcase
                write_cfg(CFG_MIN_PIN_LENGTH, {11'($urandom_range(0, 2047)), min_len});
                write_cfg(CFG_RESET_HOLD_MS, hold);
                cfg_valid <= 1'b0;
            end

            goal = keys_sent + KEYS_PER_PHASE;
            while (keys_sent < goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    if (sb.pin_saved)
                        enter_pin(1'b1, sb.stored_len, 1'b0);
                    else
                        enter_pin(1'b0, pin_len(), 1'b0);
                end
                else if (pick < 45)
                    enter_pin(1'b0, pin_len(), 1'b0);
                else if (pick < 55)
                begin
                    if (!sb.pin_saved)
                        enter_pin(1'b0, pin_len(), 1'b0);
                    else if ($urandom_range(0, 1) == 0)
                        enter_pin(1'b1, sb.stored_len, 1'b1);
                    else
                    begin
                        len = sb.stored_len + 1;
                        if ($urandom_range(0, 1) == 0 && sb.stored_len > 0)
                            len = sb.stored_len - 1;
                        enter_pin(1'b1, len, 1'b0);
                    end
                end
                else if (pick < 63)
                    send_key(KEY_BACK, any_press());
                else if (pick < 68)
                    send_key(KEY_CLEAR, clear_press(1'b1));
                else if (pick < 95)
                begin
                    len = $urandom_range(0, 16);
                    case (len)
                        11:      send_key(KEY_ENTER, any_press());
                        12:      send_key(KEY_BACK, any_press());
                        13:      send_key(KEY_CLEAR, clear_press($urandom_range(0, 3) == 0));
                        14:      send_key(KEY_DEL, any_press());
                        15:      send_key(KEY_MASK, any_press());
                        16:      send_key(KEY_NONE, any_press());
                        default: send_key(symbol_key(len), any_press());
                    endcase
                end
                else
                    send_key(8'($urandom_range(0, 255)), any_press());
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_keypad_pin_lock_controller: clean");
        else
            $display("tb_keypad_pin_lock_controller: errors");
        $finish;
    end

endmodule
